@@ rtl/decimal_id_binary_converter_top_defines.svh @@
// Assertion macros for the decimal identifier converter.
`ifndef DECIMAL_ID_BINARY_CONVERTER_TOP_DEFINES_SVH
`define DECIMAL_ID_BINARY_CONVERTER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define DIC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("converter check failed");

// Check that cons holds in the cycle after ante.
`define DIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("converter check failed");

`endif

@@ rtl/dic_pkg.sv @@
package dic_pkg;

    // Fixed field widths
    localparam int BIN_W      = 40;
    localparam int BCD_IN_W   = 48;
    // Double-dabble register: 13 digits cover any 40-bit value
    localparam int BCD_DIGITS = 13;
    localparam int BCD_W      = 4 * BCD_DIGITS;

    localparam logic [3:0] DEC_MAX   = 4'd9;
    localparam logic [3:0] DABBLE_LO = 4'd5;
    localparam logic [3:0] DABBLE_ADD = 4'd3;

    // Item kinds on the input tuser bit
    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENC,
        ST_DEC,
        ST_HOLD
    } t_state;

endpackage

@@ rtl/dic_enc.sv @@
module dic_enc #(
    parameter int DIGITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dic_pkg::BCD_IN_W-1:0] i_bcd,
    output logic                        o_done,
    output logic [dic_pkg::BIN_W-1:0]    o_value,
    output logic                        o_invalid
);
    import dic_pkg::*;

    localparam int DW = 4 * DIGITS;
    localparam int LW = (DW > BCD_IN_W) ? DW : BCD_IN_W;
    localparam int CW = $clog2(DIGITS + 1);

    logic [DW-1:0]    r_sh, n_sh;
    logic [BIN_W-1:0] r_acc, n_acc;
    logic             r_bad, n_bad;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [LW-1:0]    w_bcd;
    logic [3:0]       w_nib;

    // Digits above the input field read as zero
    assign w_bcd = LW'(i_bcd);
    assign w_nib = r_sh[DW-1 -: 4];

    // Multiply-accumulate one digit per cycle, most significant first
    always_comb begin
        n_sh   = r_sh;
        n_acc  = r_acc;
        n_bad  = r_bad;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_sh   = w_bcd[DW-1:0];
            n_acc  = '0;
            n_bad  = 1'b0;
            n_cnt  = CW'(DIGITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = (r_acc << 3) + (r_acc << 1) + BIN_W'(w_nib);
            n_bad = r_bad | (w_nib > DEC_MAX);
            n_sh  = r_sh << 4;
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_sh  <= n_sh;
        r_acc <= n_acc;
        r_bad <= n_bad;
    end

    assign o_done    = r_done;
    assign o_value   = r_acc;
    assign o_invalid = r_bad;

endmodule

@@ rtl/dic_dec.sv @@
module dic_dec #(
    parameter int DIGITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dic_pkg::BIN_W-1:0]    i_bin,
    output logic                        o_done,
    output logic [dic_pkg::BCD_IN_W-1:0] o_digits,
    output logic                        o_overflow
);
    import dic_pkg::*;

    localparam int CW        = $clog2(BIN_W + 1);
    localparam int KEEP_BITS = (4 * DIGITS > BCD_W) ? BCD_W : 4 * DIGITS;
    localparam logic [BCD_W-1:0] KEEP = {BCD_W{1'b1}} >> (BCD_W - KEEP_BITS);

    logic [BIN_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [BCD_W-1:0] w_adj;
    logic [BCD_W-1:0] w_keep;

    // Add three to every digit of five or more before the shift
    always_comb begin
        for (int k = 0; k < BCD_DIGITS; k++) begin
            w_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= DABBLE_LO) ?
                              r_bcd[4*k +: 4] + DABBLE_ADD : r_bcd[4*k +: 4];
        end
    end

    // Shift one binary bit into the digit register per cycle
    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_bin  = i_bin;
            n_bcd  = '0;
            n_cnt  = CW'(BIN_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = {w_adj[BCD_W-2:0], r_bin[BIN_W-1]};
            n_bin = r_bin << 1;
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    // Keep the low digits; any digit above them means overflow
    assign w_keep     = r_bcd & KEEP;
    assign o_digits   = w_keep[BCD_IN_W-1:0];
    assign o_overflow = |(r_bcd & ~KEEP);
    assign o_done     = r_done;

endmodule

@@ rtl/decimal_id_binary_converter_top.sv @@
// Decimal identifier converter: BCD digits to 40-bit binary and back.
// Input stream s_axis: tuser selects the kind of item (0 encode, 1 decode),
// tdata carries the BCD digits and the binary value. One result per item
// leaves on m_axis: tdata holds the binary value and the digits, tuser the
// overflow and invalid flags.
// Encode walks one BCD digit per cycle through a multiply-by-ten accumulator.
// Decode runs a double-dabble shifter, one binary bit per cycle over 40 bits.
// One item is in work at a time; s_axis_tready is high only while the
// converter is idle, so a new item is not taken until the last result
// has been loaded into the output register.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls while a second result finishes, that
// result holds in the converter and input stays blocked until it moves.
// Reset (synchronous, active low) drops any item in work and clears
// m_axis_tvalid; the converter keeps no state between items.
module decimal_id_binary_converter_top #(
    parameter int DIGITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // [47:0] decimal_digits, [87:48] binary_value
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // [39:0] binary_out, [87:40] digits_out
    output logic [1:0]  m_axis_tuser    // [0] overflow, [1] invalid
);
    import dic_pkg::*;

    t_state r_state, n_state;
    logic   r_action;
    logic   r_m_valid;
    logic [87:0] r_m_data;
    logic [1:0]  r_m_user;

    logic w_accept;
    logic w_out_free;
    logic w_enc_start, w_dec_start;
    logic w_load;
    logic w_enc_done, w_dec_done;
    logic [BIN_W-1:0]    w_enc_value;
    logic                w_enc_invalid;
    logic [BCD_IN_W-1:0] w_dec_digits;
    logic                w_dec_overflow;

    dic_enc #(.DIGITS(DIGITS)) u_enc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_enc_start),
        .i_bcd     (s_axis_tdata[BCD_IN_W-1:0]),
        .o_done    (w_enc_done),
        .o_value   (w_enc_value),
        .o_invalid (w_enc_invalid)
    );

    dic_dec #(.DIGITS(DIGITS)) u_dec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dec_start),
        .i_bin      (s_axis_tdata[BCD_IN_W +: BIN_W]),
        .o_done     (w_dec_done),
        .o_digits   (w_dec_digits),
        .o_overflow (w_dec_overflow)
    );

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (s_axis_tuser == ACT_DECODE) ? ST_DEC : ST_ENC;
                end
            end
            ST_ENC: begin
                if (w_enc_done) begin
                    n_state = w_out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_DEC: begin
                if (w_dec_done) begin
                    n_state = w_out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_load        = 1'b0;
        case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_ENC:  w_load = w_enc_done && w_out_free;
            ST_DEC:  w_load = w_dec_done && w_out_free;
            ST_HOLD: w_load = w_out_free;
            default: w_load = 1'b0;
        endcase
    end

    assign w_enc_start = w_accept && (s_axis_tuser == ACT_ENCODE);
    assign w_dec_start = w_accept && (s_axis_tuser == ACT_DECODE);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Remember the item kind and load the result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= s_axis_tuser;
        end
        if (w_load) begin
            if (r_action == ACT_DECODE) begin
                r_m_data <= {w_dec_digits, {BIN_W{1'b0}}};
                r_m_user <= {1'b0, w_dec_overflow};
            end else begin
                r_m_data <= {{BCD_IN_W{1'b0}}, w_enc_value};
                r_m_user <= {w_enc_invalid, 1'b0};
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

@@ rtl/dic_checker.sv @@
`include "decimal_id_binary_converter_top_defines.svh"

module dic_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic        w_in_take;
    logic        w_out_wait;
    logic        w_kind_ok;
    logic [89:0] w_out_bits;

    // Combine the port terms that the checks below look at
    assign w_in_take  = s_axis_tvalid && s_axis_tready;
    assign w_out_wait = m_axis_tvalid && !m_axis_tready;
    assign w_out_bits = {m_axis_tuser, m_axis_tdata};
    assign w_kind_ok  = (m_axis_tdata[39:0] == 40'd0 || m_axis_tdata[87:40] == 48'd0) &&
                        !(m_axis_tuser[0] && m_axis_tuser[1]);

    // Hold a stalled result
    `DIC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_wait, m_axis_tvalid && $stable(w_out_bits))

    // Take one item at a time
    `DIC_ASSERT_NEXT(a_one_in_work, i_clk, i_rst_n, w_in_take, !s_axis_tready)

    // A result is either an encode or a decode, never both
    `DIC_ASSERT_NOW(a_one_kind, i_clk, i_rst_n, m_axis_tvalid, w_kind_ok)

    // Drop the output after reset
    `DIC_ASSERT_NEXT(a_reset_clear, i_clk, 1'b1, !i_rst_n, !m_axis_tvalid)

endmodule

bind decimal_id_binary_converter_top dic_checker u_dic_checker (.*);
